/* sv/pp_pkg.sv */
// shared types, constants and the arctangent table for the pure pursuit steering block
// no dependencies
package pp_pkg;

  localparam int MaxWaypoints = 256;
  localparam int IdxCapInt    = ((MaxWaypoints - 1) > 255) ? 255 : (MaxWaypoints - 1);
  localparam logic [7:0] IdxCap = 8'(IdxCapInt);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // angles in units of 2^-28 rad
  localparam logic signed [32:0] PiA     = 33'sd843314857;
  localparam logic signed [32:0] HalfPiA = 33'sd421657428;
  localparam logic signed [32:0] TwoPiA  = 33'sd1686629714;
  localparam logic signed [33:0] InvKQ30 = 34'sd652032874;
  localparam logic [4:0]         CordLast = 5'd27;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_HORIZON   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WHEELBASE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STOP_DIST = 2'd2;

  localparam logic [23:0] HorizonRst   = 24'd393216;
  localparam logic [19:0] WheelbaseRst = 20'd122421;
  localparam logic [19:0] StopDistRst  = 20'd32768;

  typedef struct packed {
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic signed [15:0] wp_speed;
    logic               last_point;
    logic signed [31:0] veh_x;
    logic signed [31:0] veh_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    item_t       item;
  } q_head_t;

  typedef struct packed {
    logic [23:0] horizon;
    logic [19:0] wheelbase;
    logic [19:0] stop_distance;
  } cfg_t;

  function automatic logic [27:0] atan_tab(input logic [4:0] i);
    logic [27:0] v;
    case (i)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      5'd24: v = 28'd16;
      5'd25: v = 28'd8;
      5'd26: v = 28'd4;
      5'd27: v = 28'd2;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/pp_cordic.sv */
// shared cordic unit, vectoring or rotation mode, one iteration per cycle
// depends on pp_pkg
module pp_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                vec_mode,
  input  logic signed [33:0]  x0,
  input  logic signed [33:0]  y0,
  input  logic signed [32:0]  z0,
  output logic                done,
  output logic signed [33:0]  y_out,
  output logic signed [32:0]  z_out
);
  import pp_pkg::*;

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [4:0]         i_r, i_nxt;
  logic               run_r, run_nxt, mode_r, mode_nxt, done_r, done_nxt;

  logic signed [33:0] xs, ys;
  logic signed [32:0] ang;
  logic               cw;

  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  assign ang = {5'b0, atan_tab(i_r)};
  assign cw  = mode_r ? (y_r >= 0) : (z_r < 0);

  // one micro-rotation per cycle
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    run_nxt  = run_r;
    mode_nxt = mode_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = x0;
      y_nxt    = y0;
      z_nxt    = z0;
      i_nxt    = 5'd0;
      run_nxt  = 1'b1;
      mode_nxt = vec_mode;
    end else if (run_r) begin
      if (cw) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + ang;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - ang;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == CordLast) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    i_r    <= i_nxt;
    mode_r <= mode_nxt;
  end

  assign done  = done_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

/* sv/pp_isqrt.sv */
// integer square root, one result bit per cycle
// no package dependencies
module pp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] v_in,
  output logic        done,
  output logic [30:0] root
);

  logic [61:0] v_r, v_nxt, r_r, r_nxt, b_r, b_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [61:0] rb;

  assign rb = r_r + b_r;

  // restoring digit step
  always_comb begin
    v_nxt    = v_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt   = v_in;
      r_nxt   = '0;
      b_nxt   = 62'd1 << 60;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (v_r >= rb) begin
        v_nxt = v_r - rb;
        r_nxt = (r_r >> 1) + b_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      b_nxt = b_r >> 2;
      if (b_r[0]) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    v_r <= v_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign root = r_r[30:0];

endmodule

/* sv/pp_front.sv */
// front end: accepts waypoint requests into a short queue and tags path ends
// depends on pp_pkg
module pp_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pp_pkg::item_t    in_item,
  input  logic             pop,
  output pp_pkg::q_head_t  head
);
  import pp_pkg::*;

  item_t             mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  cnt_r, cnt_nxt;
  logic              push, do_pop;

  assign in_ready = (cnt_r != QCntW'(QDepth));
  assign push     = in_valid && in_ready;
  assign do_pop   = pop && (cnt_r != '0);

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  // head of queue with its path-end tag
  always_comb begin
    head.valid = (cnt_r != '0);
    head.item  = mem_r[rd_ptr_r];
    head.last  = mem_r[rd_ptr_r].last_point;
  end

endmodule

/* sv/pp_back.sv */
// back end: path length accumulation, target latch and steering law sequencer
// depends on pp_pkg, pp_isqrt, pp_cordic
module pp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pp_pkg::cfg_t       cfg,
  input  pp_pkg::q_head_t    head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_speed_cmd,
  output logic signed [15:0] out_steer_angle,
  output logic               out_too_close,
  output logic [7:0]         out_target_index
);
  import pp_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SQ1   = 16'h0002,
    S_SQ2   = 16'h0004,
    S_SQ3   = 16'h0008,
    S_SQ4   = 16'h0010,
    S_ROOT  = 16'h0020,
    S_DIST  = 16'h0040,
    S_ADV   = 16'h0080,
    S_QUAT  = 16'h0100,
    S_NORM  = 16'h0200,
    S_ATAN  = 16'h0400,
    S_FOLD  = 16'h0800,
    S_SIN   = 16'h1000,
    S_NUM   = 16'h2000,
    S_SHIFT = 16'h4000,
    S_EMIT  = 16'h8000
  } state_t;

  typedef enum logic [1:0] {PH_YAW, PH_BEAR, PH_STEER} at_ph_t;

  typedef struct packed {
    item_t              item;
    logic [39:0]        path_len;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
    logic [7:0]         cnt;
    logic               found;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic [7:0]         tgt_idx;
    logic signed [15:0] first_speed;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               dist_ph;
    logic [29:0]        ax;
    logic [29:0]        ay;
    logic               hsh;
    logic signed [65:0] prod;
    logic [61:0]        sum;
    logic signed [33:0] qa;
    logic signed [33:0] qb;
    logic [2:0]         k;
    logic [40:0]        na;
    logic [40:0]        nb;
    logic               yneg;
    logic               xneg;
    logic               atz;
    at_ph_t             at_ph;
    logic signed [32:0] yaw;
    logic signed [32:0] alpha;
    logic               sneg;
    logic signed [32:0] sv;
    logic [33:0]        tdist;
    logic               close;
    logic signed [15:0] steer;
    logic signed [15:0] speed;
    logic               o_valid;
    logic signed [15:0] o_speed;
    logic signed [15:0] o_steer;
    logic               o_close;
    logic [7:0]         o_idx;
  } st_t;

  state_t state_r, state_nxt;
  st_t    st_r, st_nxt;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // iterative units
  logic               sq_go, sq_done;
  logic [61:0]        sq_v;
  logic [30:0]        sq_root;
  logic               cd_go, cd_vec, cd_done;
  logic signed [33:0] cd_x0, cd_y0, cd_y;
  logic signed [32:0] cd_z0, cd_z;

  pp_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_go),
    .v_in  (sq_v),
    .done  (sq_done),
    .root  (sq_root)
  );

  pp_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cd_go),
    .vec_mode (cd_vec),
    .x0       (cd_x0),
    .y0       (cd_y0),
    .z0       (cd_z0),
    .done     (cd_done),
    .y_out    (cd_y),
    .z_out    (cd_z)
  );

  function automatic logic signed [32:0] wrap_a(input logic signed [32:0] a);
    logic signed [32:0] r;
    r = a;
    if (a > PiA) begin
      r = a - TwoPiA;
    end else if (a < -PiA) begin
      r = a + TwoPiA;
    end
    return r;
  endfunction

  function automatic logic [40:0] mag41(input logic signed [40:0] v);
    return v[40] ? 41'(-v) : 41'(v);
  endfunction

  function automatic logic signed [32:0] sx16(input logic signed [15:0] v);
    return {{17{v[15]}}, v};
  endfunction

  // helper values
  logic [32:0]        mx, my;
  logic               big;
  logic [33:0]        hyp;
  logic [40:0]        len_sum;
  logic [39:0]        len_new;
  logic signed [32:0] at_res;
  logic signed [33:0] steer_sum;
  logic signed [65:0] num_sh;
  logic               nx_neg, ny_neg;
  logic [29:0]        cxm, cym;

  assign mx        = st_r.dx[32] ? 33'(-st_r.dx) : 33'(st_r.dx);
  assign my        = st_r.dy[32] ? 33'(-st_r.dy) : 33'(st_r.dy);
  assign big       = (mx[32:30] != 3'b0) || (my[32:30] != 3'b0);
  assign hyp       = st_r.hsh ? {sq_root, 3'b0} : {3'b0, sq_root};
  assign len_sum   = {1'b0, st_r.path_len} + {7'b0, hyp};
  assign len_new   = len_sum[40] ? '1 : len_sum[39:0];
  assign at_res    = st_r.atz ? '0 : wrap_a(cd_z);
  assign steer_sum = {at_res[32], at_res} + 34'sd16384;
  assign num_sh    = st_r.prod >>> 13;
  assign nx_neg    = st_r.xneg && (st_r.nb != '0);
  assign ny_neg    = st_r.yneg && (st_r.na != '0);
  assign cxm       = st_r.nb[29:0];
  assign cym       = st_r.na[29:0];

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ2: begin
        mul_a = {3'b0, st_r.ax};
        mul_b = {3'b0, st_r.ax};
      end
      S_SQ3: begin
        mul_a = {3'b0, st_r.ay};
        mul_b = {3'b0, st_r.ay};
      end
      S_QUAT: begin
        case (st_r.k)
          3'd0: begin
            mul_a = sx16(st_r.item.quat_x);
            mul_b = sx16(st_r.item.quat_y);
          end
          3'd1: begin
            mul_a = sx16(st_r.item.quat_w);
            mul_b = sx16(st_r.item.quat_z);
          end
          3'd2: begin
            mul_a = sx16(st_r.item.quat_w);
            mul_b = sx16(st_r.item.quat_w);
          end
          3'd3: begin
            mul_a = sx16(st_r.item.quat_x);
            mul_b = sx16(st_r.item.quat_x);
          end
          3'd4: begin
            mul_a = sx16(st_r.item.quat_y);
            mul_b = sx16(st_r.item.quat_y);
          end
          3'd5: begin
            mul_a = sx16(st_r.item.quat_z);
            mul_b = sx16(st_r.item.quat_z);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_NUM: begin
        mul_a = {13'b0, cfg.wheelbase};
        mul_b = st_r.sv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    pop       = 1'b0;
    sq_go     = 1'b0;
    sq_v      = st_r.sum + st_r.prod[61:0];
    cd_go     = 1'b0;
    cd_vec    = 1'b1;
    cd_x0     = {4'b0, cxm};
    cd_y0     = (nx_neg ^ ny_neg) ? -$signed({4'b0, cym}) : $signed({4'b0, cym});
    cd_z0     = nx_neg ? (ny_neg ? -PiA : PiA) : '0;

    // result register drains independently
    if (st_r.o_valid && out_ready) begin
      st_nxt.o_valid = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop         = 1'b1;
          st_nxt.item = head.item;
          if (st_r.cnt == 8'd0) begin
            st_nxt.first_speed = head.item.wp_speed;
            state_nxt          = S_ADV;
          end else if (!st_r.found) begin
            st_nxt.dx      = {head.item.wp_x[31], head.item.wp_x}
                             - {st_r.prev_x[31], st_r.prev_x};
            st_nxt.dy      = {head.item.wp_y[31], head.item.wp_y}
                             - {st_r.prev_y[31], st_r.prev_y};
            st_nxt.dist_ph = 1'b0;
            state_nxt      = S_SQ1;
          end else begin
            state_nxt = S_ADV;
          end
        end
      end
      // magnitudes with coarse prescale
      S_SQ1: begin
        st_nxt.hsh = big;
        st_nxt.ax  = big ? mx[32:3] : mx[29:0];
        st_nxt.ay  = big ? my[32:3] : my[29:0];
        state_nxt  = S_SQ2;
      end
      S_SQ2: begin
        st_nxt.prod = mul_p;
        state_nxt   = S_SQ3;
      end
      S_SQ3: begin
        st_nxt.sum  = st_r.prod[61:0];
        st_nxt.prod = mul_p;
        state_nxt   = S_SQ4;
      end
      S_SQ4: begin
        sq_go     = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (sq_done) begin
          if (st_r.dist_ph) begin
            st_nxt.tdist = hyp;
            state_nxt    = S_DIST;
          end else begin
            st_nxt.path_len = len_new;
            if (len_new > {16'b0, cfg.horizon}) begin
              st_nxt.found   = 1'b1;
              st_nxt.tgt_x   = st_r.item.wp_x;
              st_nxt.tgt_y   = st_r.item.wp_y;
              st_nxt.tgt_idx = st_r.cnt;
            end
            state_nxt = S_ADV;
          end
        end
      end
      // advance path bookkeeping, start the final distance on a path end
      S_ADV: begin
        st_nxt.prev_x = st_r.item.wp_x;
        st_nxt.prev_y = st_r.item.wp_y;
        if (st_r.cnt < IdxCap) begin
          st_nxt.cnt = st_r.cnt + 8'd1;
        end
        if (!st_r.item.last_point) begin
          state_nxt = S_IDLE;
        end else begin
          if (!st_r.found) begin
            st_nxt.tgt_x   = st_r.item.wp_x;
            st_nxt.tgt_y   = st_r.item.wp_y;
            st_nxt.tgt_idx = st_r.cnt;
            st_nxt.dx = {st_r.item.wp_x[31], st_r.item.wp_x}
                        - {st_r.item.veh_x[31], st_r.item.veh_x};
            st_nxt.dy = {st_r.item.wp_y[31], st_r.item.wp_y}
                        - {st_r.item.veh_y[31], st_r.item.veh_y};
          end else begin
            st_nxt.dx = {st_r.tgt_x[31], st_r.tgt_x}
                        - {st_r.item.veh_x[31], st_r.item.veh_x};
            st_nxt.dy = {st_r.tgt_y[31], st_r.tgt_y}
                        - {st_r.item.veh_y[31], st_r.item.veh_y};
          end
          st_nxt.dist_ph = 1'b1;
          state_nxt      = S_SQ1;
        end
      end
      S_DIST: begin
        st_nxt.steer = '0;
        st_nxt.speed = '0;
        if (st_r.tdist <= {14'b0, cfg.stop_distance}) begin
          st_nxt.close = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          st_nxt.close = 1'b0;
          st_nxt.k     = 3'd0;
          state_nxt    = S_QUAT;
        end
      end
      // yaw operands from quaternion products
      S_QUAT: begin
        st_nxt.prod = mul_p;
        st_nxt.k    = st_r.k + 3'd1;
        case (st_r.k)
          3'd0: begin
            st_nxt.qa = '0;
            st_nxt.qb = '0;
          end
          3'd1: st_nxt.qa = st_r.prod[33:0];
          3'd2: st_nxt.qa = st_r.qa + st_r.prod[33:0];
          3'd3: st_nxt.qb = st_r.prod[33:0];
          3'd4: st_nxt.qb = st_r.qb + st_r.prod[33:0];
          3'd5: st_nxt.qb = st_r.qb - st_r.prod[33:0];
          3'd6: st_nxt.qb = st_r.qb - st_r.prod[33:0];
          default: begin
            st_nxt.na    = mag41({st_r.qa[33], st_r.qa[33], st_r.qa[33],
                                  st_r.qa[33], st_r.qa[33], st_r.qa[33], st_r.qa, 1'b0});
            st_nxt.yneg  = st_r.qa[33];
            st_nxt.nb    = mag41({{7{st_r.qb[33]}}, st_r.qb});
            st_nxt.xneg  = st_r.qb[33];
            st_nxt.at_ph = PH_YAW;
            state_nxt    = S_NORM;
          end
        endcase
      end
      // operand normalization, one shift per cycle
      S_NORM: begin
        st_nxt.atz = 1'b0;
        if (st_r.na == '0 && st_r.nb == '0) begin
          st_nxt.atz = 1'b1;
          state_nxt  = S_ATAN;
        end else if (st_r.na[40:29] != '0 || st_r.nb[40:29] != '0) begin
          st_nxt.na = st_r.na >> 1;
          st_nxt.nb = st_r.nb >> 1;
        end else if (st_r.na[40:28] == '0 && st_r.nb[40:28] == '0) begin
          st_nxt.na = st_r.na << 1;
          st_nxt.nb = st_r.nb << 1;
        end else begin
          cd_go     = 1'b1;
          cd_vec    = 1'b1;
          state_nxt = S_ATAN;
        end
      end
      S_ATAN: begin
        if (cd_done || st_r.atz) begin
          st_nxt.atz = 1'b0;
          unique case (st_r.at_ph)
            PH_YAW: begin
              st_nxt.yaw   = at_res;
              st_nxt.na    = mag41({{8{st_r.dy[32]}}, st_r.dy});
              st_nxt.yneg  = st_r.dy[32];
              st_nxt.nb    = mag41({{8{st_r.dx[32]}}, st_r.dx});
              st_nxt.xneg  = st_r.dx[32];
              st_nxt.at_ph = PH_BEAR;
              state_nxt    = S_NORM;
            end
            PH_BEAR: begin
              st_nxt.alpha = wrap_a(at_res - st_r.yaw);
              state_nxt    = S_FOLD;
            end
            PH_STEER: begin
              st_nxt.steer = steer_sum[30:15];
              st_nxt.speed = st_r.first_speed;
              state_nxt    = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      // fold into the right half plane and rotate
      S_FOLD: begin
        cd_go  = 1'b1;
        cd_vec = 1'b0;
        cd_x0  = InvKQ30;
        cd_y0  = '0;
        if (st_r.alpha > HalfPiA) begin
          cd_z0       = st_r.alpha - PiA;
          st_nxt.sneg = 1'b1;
        end else if (st_r.alpha < -HalfPiA) begin
          cd_z0       = st_r.alpha + PiA;
          st_nxt.sneg = 1'b1;
        end else begin
          cd_z0       = st_r.alpha;
          st_nxt.sneg = 1'b0;
        end
        state_nxt = S_SIN;
      end
      S_SIN: begin
        if (cd_done) begin
          st_nxt.sv = st_r.sneg ? 33'(-cd_y) : cd_y[32:0];
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        st_nxt.prod = mul_p;
        state_nxt   = S_SHIFT;
      end
      S_SHIFT: begin
        st_nxt.na    = mag41(num_sh[40:0]);
        st_nxt.yneg  = num_sh[40];
        st_nxt.nb    = {7'b0, st_r.tdist};
        st_nxt.xneg  = 1'b0;
        st_nxt.at_ph = PH_STEER;
        state_nxt    = S_NORM;
      end
      // hand over the result and clear the path
      S_EMIT: begin
        if (!st_r.o_valid || out_ready) begin
          st_nxt.o_valid     = 1'b1;
          st_nxt.o_speed     = st_r.speed;
          st_nxt.o_steer     = st_r.steer;
          st_nxt.o_close     = st_r.close;
          st_nxt.o_idx       = st_r.tgt_idx;
          st_nxt.path_len    = '0;
          st_nxt.prev_x      = '0;
          st_nxt.prev_y      = '0;
          st_nxt.cnt         = '0;
          st_nxt.found       = 1'b0;
          st_nxt.tgt_x       = '0;
          st_nxt.tgt_y       = '0;
          st_nxt.tgt_idx     = '0;
          st_nxt.first_speed = '0;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= '0;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  assign out_valid        = st_r.o_valid;
  assign out_speed_cmd    = st_r.o_speed;
  assign out_steer_angle  = st_r.o_steer;
  assign out_too_close    = st_r.o_close;
  assign out_target_index = st_r.o_idx;

endmodule

/* sv/pure_pursuit_steering.sv */
// pure pursuit steering: a waypoint request passes the back end as accept, four square
// steps, square root and advance, or only accept and advance when no length is summed.
// a path end adds the distance steps, then the emit if too close, otherwise quaternion
// products, three arctangents and a sine, plus up to 28 normalization shifts per
// arctangent. two-entry queue ahead; one request at a time.
// synchronous active-low reset clears the path state and loads register defaults.
// depends on pp_pkg, pp_front, pp_back
module pure_pursuit_steering (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_wp_x,
  input  logic signed [31:0]          in_wp_y,
  input  logic signed [15:0]          in_wp_speed,
  input  logic                        in_last_point,
  input  logic signed [31:0]          in_veh_x,
  input  logic signed [31:0]          in_veh_y,
  input  logic signed [15:0]          in_quat_x,
  input  logic signed [15:0]          in_quat_y,
  input  logic signed [15:0]          in_quat_z,
  input  logic signed [15:0]          in_quat_w,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_speed_cmd,
  output logic signed [15:0]          out_steer_angle,
  output logic                        out_too_close,
  output logic [7:0]                  out_target_index,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [23:0]                 cfg_data
);
  import pp_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  item_t   in_item;
  q_head_t head;
  logic    pop;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_HORIZON:   cfg_nxt.horizon       = cfg_data;
        CFG_WHEELBASE: cfg_nxt.wheelbase     = cfg_data[19:0];
        CFG_STOP_DIST: cfg_nxt.stop_distance = cfg_data[19:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizon       <= HorizonRst;
      cfg_r.wheelbase     <= WheelbaseRst;
      cfg_r.stop_distance <= StopDistRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    in_item.wp_x       = in_wp_x;
    in_item.wp_y       = in_wp_y;
    in_item.wp_speed   = in_wp_speed;
    in_item.last_point = in_last_point;
    in_item.veh_x      = in_veh_x;
    in_item.veh_y      = in_veh_y;
    in_item.quat_x     = in_quat_x;
    in_item.quat_y     = in_quat_y;
    in_item.quat_z     = in_quat_z;
    in_item.quat_w     = in_quat_w;
  end

  pp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (pop),
    .head     (head)
  );

  pp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_speed_cmd    (out_speed_cmd),
    .out_steer_angle  (out_steer_angle),
    .out_too_close    (out_too_close),
    .out_target_index (out_target_index)
  );

endmodule

/* sv/pp_chk.sv */
// port-level checks for the pure pursuit steering block, bound to the top level
// depends on pure_pursuit_steering
module pp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_speed_cmd,
  input logic signed [15:0] out_steer_angle,
  input logic               out_too_close,
  input logic [7:0]         out_target_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_steer_angle)
      && $stable(out_speed_cmd) && $stable(out_target_index))
    else $error("result changed while stalled");

  // a close target gives zero commands
  a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_close |-> out_speed_cmd == 16'sd0 && out_steer_angle == 16'sd0)
    else $error("commands not zero on close target");

  // reset drops the result
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pure_pursuit_steering pp_chk u_pp_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_speed_cmd    (out_speed_cmd),
  .out_steer_angle  (out_steer_angle),
  .out_too_close    (out_too_close),
  .out_target_index (out_target_index)
);

/* tb/pure_pursuit_steering_tb.sv */
// self-checking testbench for pure_pursuit_steering: random and directed paths with a
// bit-exact predictor of length, target and cordic steering law; depends on pp_pkg
module pure_pursuit_steering_tb;
  import pp_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int IdleWait   = 600;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam longint PiQ28    = 843314857;
  localparam longint HalfPiQ28 = 421657428;
  localparam longint TwoPiQ28 = 1686629714;
  localparam longint InvKQ30L = 652032874;
  localparam longint unsigned LenMax = (64'd1 << 40) - 1;
  localparam longint AtanQ28 [28] = '{210828714, 124459457, 65760959, 33381290, 16755422,
    8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] steer;
    logic               close;
    logic [7:0]         idx;
  } steer_cmd_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_wp_x = '0, in_wp_y = '0, in_veh_x = '0, in_veh_y = '0;
  logic signed [15:0] in_wp_speed = '0, in_quat_x = '0, in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0, in_quat_w = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_speed_cmd, out_steer_angle;
  logic out_too_close;
  logic [7:0] out_target_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  pure_pursuit_steering dut (.*);

  // predictor state
  longint unsigned cur_horizon, cur_wheelbase, cur_stop;
  longint unsigned path_len;
  longint prev_x, prev_y, tgt_x, tgt_y;
  int unsigned pt_count, tgt_idx;
  logic [15:0] first_spd;
  bit tgt_found;

  item_t waypoints_pending[$];
  steer_cmd_t cmds_expected[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned absval(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned seg_len(longint dx, longint dy);
    longint unsigned ax = absval(dx), ay = absval(dy);
    int s = 0;
    if (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) s = 3;
    ax >>= s;
    ay >>= s;
    return isqrt64(ax * ax + ay * ay) << s;
  endfunction

  function automatic longint wrap_pi(longint a);
    if (a > PiQ28) a -= TwoPiQ28;
    else if (a < -PiQ28) a += TwoPiQ28;
    return a;
  endfunction

  // vectoring cordic, result in 2^-28 rad
  function automatic longint angle_of(longint y, longint x);
    longint unsigned ax = absval(x), ay = absval(y);
    longint cx, cy, tx, z = 0;
    if (ax == 0 && ay == 0) return 0;
    while (ax >= (64'd1 << 29) || ay >= (64'd1 << 29)) begin
      ax >>= 1;
      ay >>= 1;
    end
    while (ax < (64'd1 << 28) && ay < (64'd1 << 28)) begin
      ax <<= 1;
      ay <<= 1;
    end
    cx = x < 0 ? -longint'(ax) : longint'(ax);
    cy = y < 0 ? -longint'(ay) : longint'(ay);
    if (cx < 0) begin
      z = cy < 0 ? -PiQ28 : PiQ28;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < 28; i++) begin
      tx = cx;
      if (cy >= 0) begin
        cx += cy >>> i;
        cy -= tx >>> i;
        z += AtanQ28[i];
      end else begin
        cx -= cy >>> i;
        cy += tx >>> i;
        z -= AtanQ28[i];
      end
    end
    return wrap_pi(z);
  endfunction

  // rotation cordic, sine in Q1.30
  function automatic longint sine_q30(longint z);
    longint x = InvKQ30L, y = 0, tx;
    bit neg = 0;
    if (z > HalfPiQ28) begin
      z -= PiQ28;
      neg = 1;
    end else if (z < -HalfPiQ28) begin
      z += PiQ28;
      neg = 1;
    end
    for (int i = 0; i < 28; i++) begin
      tx = x;
      if (z >= 0) begin
        x -= y >>> i;
        y += tx >>> i;
        z -= AtanQ28[i];
      end else begin
        x += y >>> i;
        y -= tx >>> i;
        z += AtanQ28[i];
      end
    end
    return neg ? -y : y;
  endfunction

  function automatic void clear_path();
    path_len = 0;
    prev_x = 0;
    prev_y = 0;
    pt_count = 0;
    tgt_found = 0;
    tgt_x = 0;
    tgt_y = 0;
    tgt_idx = 0;
    first_spd = '0;
  endfunction

  // advance the path state by one waypoint, queue a steering command on the path end
  function automatic void track_waypoint(item_t it);
    longint x = it.wp_x, y = it.wp_y;
    longint dx, dy, qx, qy, qz, qw, yaw, alpha, s, num, theta;
    longint unsigned tgt_dist;
    int unsigned idx = pt_count;
    steer_cmd_t c;
    if (idx == 0) begin
      first_spd = it.wp_speed;
    end else if (!tgt_found) begin
      path_len += seg_len(x - prev_x, y - prev_y);
      if (path_len > LenMax) path_len = LenMax;
      if (path_len > cur_horizon) begin
        tgt_found = 1;
        tgt_x = x;
        tgt_y = y;
        tgt_idx = idx;
      end
    end
    prev_x = x;
    prev_y = y;
    if (pt_count < IdxCapInt) pt_count++;
    if (!it.last_point) return;
    if (!tgt_found) begin
      tgt_x = x;
      tgt_y = y;
      tgt_idx = idx;
    end
    dx = tgt_x - longint'(it.veh_x);
    dy = tgt_y - longint'(it.veh_y);
    qx = it.quat_x;
    qy = it.quat_y;
    qz = it.quat_z;
    qw = it.quat_w;
    tgt_dist = seg_len(dx, dy);
    c.close = tgt_dist <= cur_stop;
    c.speed = '0;
    c.steer = '0;
    c.idx = tgt_idx[7:0];
    if (!c.close) begin
      yaw = angle_of(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
      alpha = wrap_pi(angle_of(dy, dx) - yaw);
      s = sine_q30(alpha);
      num = (longint'(cur_wheelbase) * s) >>> 13;
      theta = angle_of(num, longint'(tgt_dist));
      c.steer = 16'((theta + 16384) >>> 15);
      c.speed = first_spd;
    end
    cmds_expected.push_back(c);
    clear_path();
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // waypoint request driver
  int in_gap = 0;
  item_t in_cur;
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        track_waypoint(in_cur);
        busy = 0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (waypoints_pending.size() > 0) begin
          in_cur = waypoints_pending.pop_front();
          in_wp_x <= in_cur.wp_x;
          in_wp_y <= in_cur.wp_y;
          in_wp_speed <= in_cur.wp_speed;
          in_last_point <= in_cur.last_point;
          in_veh_x <= in_cur.veh_x;
          in_veh_y <= in_cur.veh_y;
          in_quat_x <= in_cur.quat_x;
          in_quat_y <= in_cur.quat_y;
          in_quat_z <= in_cur.quat_z;
          in_quat_w <= in_cur.quat_w;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int out_stall = 0;
  always @(posedge clk) begin
    steer_cmd_t c;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cmds_expected.size() == 0) begin
          report("unexpected result, target_index", out_target_index, -1);
        end else begin
          c = cmds_expected.pop_front();
          if (out_speed_cmd !== c.speed) report("speed_cmd", out_speed_cmd, c.speed);
          if (out_steer_angle !== c.steer) report("steer_angle", out_steer_angle, c.steer);
          if (out_too_close !== c.close) report("too_close", out_too_close, c.close);
          if (out_target_index !== c.idx) report("target_index", out_target_index, c.idx);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL pure_pursuit_steering");
      $finish;
    end
  end

  task automatic settle();
    while (waypoints_pending.size() > 0 || in_valid || cmds_expected.size() > 0)
      @(posedge clk);
    repeat (IdleWait) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HORIZON:   cur_horizon = data;
      CFG_WHEELBASE: cur_wheelbase = data[19:0];
      CFG_STOP_DIST: cur_stop = data[19:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_quat();
    int r = $urandom_range(0, 9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    if (r < 4) return 16'($urandom_range(0, 32767)) - 16'sd16384;
    return 16'($urandom);
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.wp_x = $urandom;
    it.wp_y = $urandom;
    it.wp_speed = 16'($urandom);
    it.last_point = 1'b0;
    it.veh_x = $urandom;
    it.veh_y = $urandom;
    it.quat_x = rand_quat();
    it.quat_y = rand_quat();
    it.quat_z = rand_quat();
    it.quat_w = rand_quat();
    return it;
  endfunction

  // one path: random walk of n waypoints; mode picks the step scale, mode 3 places each point at random
  task automatic add_path(int n, int mode);
    item_t it;
    logic signed [31:0] px, py, fx, fy;
    int stp, r;
    stp = mode == 0 ? 1 << 18 : (mode == 1 ? 1 << 22 : 0);
    px = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    py = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    fx = px;
    fy = py;
    for (int k = 0; k < n; k++) begin
      it = rand_item();
      if (mode == 3) begin
        px = $urandom;
        py = $urandom;
      end
      it.wp_x = px;
      it.wp_y = py;
      it.last_point = k == n - 1;
      if (it.last_point) begin
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) begin
          it.quat_x = '0;
          it.quat_y = '0;
          it.quat_z = '0;
          it.quat_w = '0;
        end
        if (r < 6) begin
          it.veh_x = fx + int'($urandom_range(0, 1 << 19)) - (1 << 18);
          it.veh_y = fy + int'($urandom_range(0, 1 << 19)) - (1 << 18);
        end else if (r < 8) begin
          it.veh_x = px;
          it.veh_y = py;
        end
      end
      waypoints_pending.push_back(it);
      if (stp > 0) begin
        px += int'($urandom_range(0, 2 * stp)) - stp;
        py += int'($urandom_range(0, 2 * stp)) - stp;
      end
    end
  endtask

  task automatic random_paths(int items);
    int n, m;
    while (items > 0) begin
      n = $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 12);
      m = $urandom_range(0, 9);
      add_path(n, m < 6 ? 0 : (m < 8 ? 1 : (m < 9 ? 2 : 3)));
      items -= n;
    end
    settle();
  endtask

  task automatic directed();
    item_t it;
    // single waypoint, zero quaternion, far vehicle
    it = rand_item();
    it.last_point = 1'b1;
    it.quat_x = '0;
    it.quat_y = '0;
    it.quat_z = '0;
    it.quat_w = '0;
    it.wp_speed = 16'sh7fff;
    waypoints_pending.push_back(it);
    // vehicle on target
    it = rand_item();
    it.last_point = 1'b1;
    it.veh_x = it.wp_x;
    it.veh_y = it.wp_y;
    waypoints_pending.push_back(it);
    // field extremes
    for (int k = 0; k < 4; k++) begin
      it.wp_x = k[0] ? 32'sh7fffffff : 32'sh80000000;
      it.wp_y = k[1] ? 32'sh80000000 : 32'sh7fffffff;
      it.wp_speed = k[0] ? 16'sh8000 : 16'sh7fff;
      it.veh_x = k[1] ? 32'sh7fffffff : 32'sh80000000;
      it.veh_y = k[0] ? 32'sh7fffffff : 32'sh80000000;
      it.quat_x = k[0] ? 16'sh8000 : 16'sh7fff;
      it.quat_y = k[1] ? 16'sh7fff : 16'sh8000;
      it.quat_z = k[0] ? 16'sh7fff : 16'sh8000;
      it.quat_w = k[1] ? 16'sh8000 : 16'sh7fff;
      it.last_point = k[0];
      waypoints_pending.push_back(it);
    end
    // four short random-walk paths of three waypoints each
    for (int k = 0; k < 4; k++) begin
      add_path(3, 0);
    end
    settle();
  endtask

  initial begin
    cur_horizon = HorizonRst;
    cur_wheelbase = WheelbaseRst;
    cur_stop = StopDistRst;
    clear_path();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();
    // long path saturates the waypoint index
    add_path(300, 2);
    settle();
    random_paths(200);

    write_reg(CFG_HORIZON, 24'd0);
    write_reg(CFG_WHEELBASE, 24'hffffff);
    write_reg(CFG_STOP_DIST, 24'd0);
    random_paths(200);

    write_reg(CFG_HORIZON, 24'hffffff);
    write_reg(CFG_WHEELBASE, 24'd0);
    write_reg(CFG_STOP_DIST, 24'hffffff);
    random_paths(150);

    calm = 1;
    write_reg(CFG_HORIZON, 24'($urandom_range(1 << 16, 1 << 21)));
    write_reg(CFG_WHEELBASE, {4'hf, 20'($urandom_range(1 << 15, 1 << 18))});
    write_reg(CFG_STOP_DIST, {4'ha, 20'($urandom_range(0, 1 << 16))});
    write_reg(CfgUnused, 24'($urandom));
    random_paths(250);
    calm = 0;

    write_reg(CFG_HORIZON, HorizonRst);
    write_reg(CFG_WHEELBASE, 24'(WheelbaseRst));
    write_reg(CFG_STOP_DIST, 24'(StopDistRst));
    random_paths(270);

    if (errors == 0 && cmds_expected.size() == 0) begin
      $display("PASS pure_pursuit_steering");
    end else begin
      $display("FAIL pure_pursuit_steering");
    end
    $finish;
  end

endmodule
